### rtl/lzo_pkg.sv
// layer z-order table: shared command codes, status codes and field types
`default_nettype none

package lzo_pkg;

  // item field widths
  localparam int CMD_W    = 2;
  localparam int ID_W     = 8;
  localparam int HGT_W    = 9;
  localparam int STATUS_W = 2;

  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic [STATUS_W-1:0]      status_t;
  typedef logic [ID_W-1:0]          layer_id_t;
  typedef logic signed [HGT_W-1:0]  height_t;

  // commands
  localparam cmd_t CMD_ALLOC = 2'd0;
  localparam cmd_t CMD_SET   = 2'd1;
  localparam cmd_t CMD_FREE  = 2'd2;
  localparam cmd_t CMD_NOP   = 2'd3;

  // result status codes
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_NO_FREE  = 2'd1;
  localparam status_t STATUS_NOT_USED = 2'd2;

endpackage

`default_nettype wire

### rtl/lzo_ram.sv
// generic simple dual-port ram, one write port and one registered read port
`default_nettype none

module lzo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/layer_z_order_table.sv
// Layer z-order table: slot allocation and stack reordering of display layers.
//
// Input channel (in_valid / in_stall): one command item, taken when in_valid is
// high and in_stall is low. Commands: allocate the lowest free slot, set the
// height of a slot, free a slot, or no operation.
// Result channel (out_valid / out_stall): exactly one result item per command,
// carrying the slot, status, final height, new top height and a redraw flag.
//
// After reset the slot table is cleared one entry a cycle; in_stall stays high
// meanwhile and top height is -1. Allocate scans the slot table one entry a
// cycle up to the lowest free slot, or to the last entry when none is free.
// Set height and free shift by one place the stack entries that the move passes
// over, up to LAYER_COUNT - 1 of them; refusals and no operation shift nothing.
// The shift goes through the order memory one entry a cycle.
// One item is in work at a time; in_stall is low only while idle, from the
// cycle after each result is loaded.
// A finished result sits in an output register, so the next item is taken while
// the receiver stalls; that item's result waits until the register is free.
`default_nettype none

module layer_z_order_table #(
  parameter int LAYER_COUNT = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic        [lzo_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic        [lzo_pkg::ID_W-1:0]    in_layer_id,
  input  wire logic signed [lzo_pkg::HGT_W-1:0]   in_requested_height,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic             [lzo_pkg::ID_W-1:0]    out_result_layer,
  output logic             [lzo_pkg::STATUS_W-1:0] out_status,
  output logic signed      [lzo_pkg::HGT_W-1:0]   out_final_height,
  output logic signed      [lzo_pkg::HGT_W-1:0]   out_top_height,
  output logic                                    out_changed
);

  localparam int IW   = $clog2(LAYER_COUNT);
  localparam int HW   = IW + 1;
  localparam int CW   = ((HW > lzo_pkg::HGT_W) ? HW : lzo_pkg::HGT_W) + 1;
  localparam int CNTW = IW + 1;
  localparam int SW   = HW + 1;

  localparam logic signed [HW-1:0] NEG1_H = '1;
  localparam logic signed [CW-1:0] NEG1_C = '1;
  localparam logic [IW-1:0]        LAST_IDX = IW'(LAYER_COUNT - 1);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic chk_v_r, chk_v_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;

  lzo_pkg::cmd_t      cmd_r, cmd_nxt;
  lzo_pkg::layer_id_t id_r, id_nxt;
  lzo_pkg::height_t   want_r, want_nxt;

  logic signed [HW-1:0] top_r, top_nxt;
  logic signed [HW-1:0] old_r, old_nxt;
  logic signed [HW-1:0] nh_r, nh_nxt;
  logic signed [HW-1:0] src_r, src_nxt;
  logic dir_up_r, dir_up_nxt;
  logic [CNTW-1:0] rem_r, rem_nxt;
  logic pv_r, pv_nxt;
  logic [IW-1:0] pdst_r, pdst_nxt;

  lzo_pkg::layer_id_t   rs_layer_r, rs_layer_nxt;
  lzo_pkg::status_t     rs_status_r, rs_status_nxt;
  logic signed [HW-1:0] rs_fin_r, rs_fin_nxt;
  logic rs_chg_r, rs_chg_nxt;

  logic out_valid_r;
  lzo_pkg::layer_id_t out_layer_r;
  lzo_pkg::status_t   out_status_r;
  lzo_pkg::height_t   out_fin_r;
  lzo_pkg::height_t   out_top_r;
  logic out_chg_r;
  logic out_load;

  // slot table: {in use, height}
  logic slot_we;
  logic [IW-1:0] slot_waddr, slot_raddr;
  logic [SW-1:0] slot_wdata, slot_rd;

  // stack order: slot shown at each height
  logic ord_we;
  logic [IW-1:0] ord_waddr, ord_raddr;
  logic [IW-1:0] ord_wdata, ord_rd;

  lzo_ram #(.WIDTH(SW), .DEPTH(LAYER_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rd)
  );

  lzo_ram #(.WIDTH(IW), .DEPTH(LAYER_COUNT)) u_order_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_rd)
  );

  // eval: clamp the requested height and plan the shift
  logic                 id_ok;
  logic                 slot_use;
  logic signed [HW-1:0] slot_hgt;
  logic signed [CW-1:0] want_c, t_c, old_c, lim_c, nh_c;

  always_comb begin
    id_ok    = (32'(id_r) < LAYER_COUNT);
    slot_use = slot_rd[HW];
    slot_hgt = slot_rd[HW-1:0];
    want_c   = (cmd_r == lzo_pkg::CMD_FREE) ? NEG1_C : CW'(want_r);
    t_c      = CW'(top_r);
    old_c    = CW'(slot_hgt);
    lim_c    = (old_c >= 0) ? t_c : t_c + CW'(1);
    nh_c     = (want_c < NEG1_C) ? NEG1_C : want_c;
    if (nh_c > lim_c) begin
      nh_c = lim_c;
    end
  end

  // sequencer next state and memory ports
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    chk_v_nxt     = chk_v_r;
    chk_idx_nxt   = chk_idx_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    want_nxt      = want_r;
    top_nxt       = top_r;
    old_nxt       = old_r;
    nh_nxt        = nh_r;
    src_nxt       = src_r;
    dir_up_nxt    = dir_up_r;
    rem_nxt       = rem_r;
    pv_nxt        = 1'b0;
    pdst_nxt      = pdst_r;
    rs_layer_nxt  = rs_layer_r;
    rs_status_nxt = rs_status_r;
    rs_fin_nxt    = rs_fin_r;
    rs_chg_nxt    = rs_chg_r;
    out_load      = 1'b0;

    slot_we    = 1'b0;
    slot_waddr = IW'(id_r);
    slot_wdata = '0;
    slot_raddr = IW'(id_r);
    ord_we     = 1'b0;
    ord_waddr  = pdst_r;
    ord_wdata  = ord_rd;
    ord_raddr  = src_r[IW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        // clearing pass over the slot table
        slot_we    = 1'b1;
        slot_waddr = cnt_r[IW-1:0];
        slot_wdata = '0;
        cnt_nxt    = cnt_r + CNTW'(1);
        if (cnt_r[IW-1:0] == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          id_nxt    = in_layer_id;
          want_nxt  = in_requested_height;
          cnt_nxt   = '0;
          chk_v_nxt = 1'b0;
          state_nxt = (in_cmd == lzo_pkg::CMD_ALLOC) ? S_ALLOC : S_LOOK;
        end
      end

      S_ALLOC: begin
        // lowest free slot, one entry a cycle
        slot_raddr = cnt_r[IW-1:0];
        if (chk_v_r && !slot_rd[HW]) begin
          slot_we       = 1'b1;
          slot_waddr    = chk_idx_r;
          slot_wdata    = {1'b1, NEG1_H};
          rs_layer_nxt  = lzo_pkg::ID_W'(chk_idx_r);
          rs_status_nxt = lzo_pkg::STATUS_OK;
          rs_fin_nxt    = NEG1_H;
          rs_chg_nxt    = 1'b0;
          state_nxt     = S_DONE;
        end else if (chk_v_r && (chk_idx_r == LAST_IDX)) begin
          rs_layer_nxt  = '0;
          rs_status_nxt = lzo_pkg::STATUS_NO_FREE;
          rs_fin_nxt    = NEG1_H;
          rs_chg_nxt    = 1'b0;
          state_nxt     = S_DONE;
        end else begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = cnt_r[IW-1:0];
          cnt_nxt     = cnt_r + CNTW'(1);
        end
      end

      S_LOOK: begin
        // slot entry read issued at the addressed id
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        rs_layer_nxt = id_r;
        rs_chg_nxt   = 1'b0;
        rs_fin_nxt   = NEG1_H;
        if (cmd_r == lzo_pkg::CMD_NOP) begin
          rs_status_nxt = lzo_pkg::STATUS_OK;
          if (id_ok && slot_use) begin
            rs_fin_nxt = slot_hgt;
          end
          state_nxt = S_DONE;
        end else if (!(id_ok && slot_use)) begin
          rs_status_nxt = lzo_pkg::STATUS_NOT_USED;
          state_nxt     = S_DONE;
        end else begin
          old_nxt   = slot_hgt;
          nh_nxt    = HW'(nh_c);
          state_nxt = S_SHIFT;
          if (old_c > nh_c) begin
            if (nh_c >= 0) begin
              // moving down: layers in between move up
              src_nxt    = HW'(old_c - CW'(1));
              dir_up_nxt = 1'b0;
              rem_nxt    = CNTW'(old_c - nh_c);
            end else begin
              // hiding: layers above move down
              src_nxt    = HW'(old_c + CW'(1));
              dir_up_nxt = 1'b1;
              rem_nxt    = CNTW'(t_c - old_c);
            end
          end else if (old_c < nh_c) begin
            if (old_c >= 0) begin
              // moving up: layers in between move down
              src_nxt    = HW'(old_c + CW'(1));
              dir_up_nxt = 1'b1;
              rem_nxt    = CNTW'(nh_c - old_c);
            end else begin
              // showing: layers from the new height up move up
              src_nxt    = top_r;
              dir_up_nxt = 1'b0;
              rem_nxt    = CNTW'(t_c - nh_c + CW'(1));
            end
          end else begin
            rem_nxt = '0;
          end
        end
      end

      S_SHIFT: begin
        // read one order entry a cycle, write it back one place over
        if (pv_r) begin
          ord_we     = 1'b1;
          ord_waddr  = pdst_r;
          ord_wdata  = ord_rd;
          slot_we    = 1'b1;
          slot_waddr = ord_rd;
          slot_wdata = {1'b1, 1'b0, pdst_r};
        end
        if (rem_r != '0) begin
          pv_nxt   = 1'b1;
          pdst_nxt = dir_up_r ? IW'(src_r - HW'(1)) : IW'(src_r + HW'(1));
          src_nxt  = dir_up_r ? src_r + HW'(1) : src_r - HW'(1);
          rem_nxt  = rem_r - CNTW'(1);
        end else if (!pv_r) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // place the layer, update its slot entry and the top
        if ((old_r != nh_r) && !nh_r[HW-1]) begin
          ord_we    = 1'b1;
          ord_waddr = nh_r[IW-1:0];
          ord_wdata = IW'(id_r);
        end
        slot_we    = 1'b1;
        slot_waddr = IW'(id_r);
        slot_wdata = {(cmd_r == lzo_pkg::CMD_SET), nh_r};
        if (old_r != nh_r) begin
          if (nh_r[HW-1]) begin
            top_nxt = top_r - HW'(1);
          end else if (old_r[HW-1]) begin
            top_nxt = top_r + HW'(1);
          end
        end
        rs_status_nxt = lzo_pkg::STATUS_OK;
        rs_fin_nxt    = nh_r;
        rs_chg_nxt    = (old_r != nh_r);
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      chk_v_r <= 1'b0;
      pv_r    <= 1'b0;
      top_r   <= NEG1_H;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      chk_v_r <= chk_v_nxt;
      pv_r    <= pv_nxt;
      top_r   <= top_nxt;
    end
  end

  // working registers of the item in progress
  always_ff @(posedge clk) begin
    chk_idx_r   <= chk_idx_nxt;
    cmd_r       <= cmd_nxt;
    id_r        <= id_nxt;
    want_r      <= want_nxt;
    old_r       <= old_nxt;
    nh_r        <= nh_nxt;
    src_r       <= src_nxt;
    dir_up_r    <= dir_up_nxt;
    rem_r       <= rem_nxt;
    pdst_r      <= pdst_nxt;
    rs_layer_r  <= rs_layer_nxt;
    rs_status_r <= rs_status_nxt;
    rs_fin_r    <= rs_fin_nxt;
    rs_chg_r    <= rs_chg_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_layer_r  <= rs_layer_r;
      out_status_r <= rs_status_r;
      out_fin_r    <= lzo_pkg::HGT_W'(rs_fin_r);
      out_top_r    <= lzo_pkg::HGT_W'(top_r);
      out_chg_r    <= rs_chg_r;
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_layer = out_layer_r;
  assign out_status       = out_status_r;
  assign out_final_height = out_fin_r;
  assign out_top_height   = out_top_r;
  assign out_changed      = out_chg_r;

endmodule

`default_nettype wire

### dv/tb_layer_z_order_table.sv
// testbench for the layer z-order table: self-checking, with its own stack predictor
`timescale 1ns / 1ps

module tb_layer_z_order_table;

  localparam int SLOTS = 256;

  // one expected result item, heights held sign-extended
  typedef struct {
    int layer;
    int status;
    int fin;
    int top;
    int chg;
  } layer_result_t;

  // predicts the layer stack and keeps the results still owed by the block
  class layer_stack_board;
    int            stack_slot[SLOTS];
    int            slot_height[SLOTS];
    bit            slot_used[SLOTS];
    int            top;
    layer_result_t awaited_results[$];
    int            errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        stack_slot[i] = 0;
        slot_height[i] = 0;
        slot_used[i] = 1'b0;
      end
      top = -1;
      errors = 0;
    endfunction

    // random slot currently in use, or the given one when none is
    function int pick_used(int fallback);
      int used[$];
      for (int i = 0; i < SLOTS; i++)
        if (slot_used[i]) used.push_back(i);
      if (used.size() == 0) return fallback;
      return used[$urandom_range(used.size() - 1)];
    endfunction

    // move one slot to a clamped height, shifting the layers in between
    function void restack(int id, int want, output int fin, output int chg);
      int old;
      int t;
      int lim;
      int nh;
      old = slot_height[id];
      t = top;
      lim = (old >= 0) ? t : t + 1;
      nh = want;
      if (nh < -1) nh = -1;
      if (nh > lim) nh = lim;
      if (old > nh) begin
        if (nh >= 0) begin
          // moving down: layers in between go up by one
          for (int k = old; k > nh; k--) begin
            stack_slot[k] = stack_slot[k-1];
            slot_height[stack_slot[k]] = k;
          end
          stack_slot[nh] = id;
        end else begin
          // hiding: layers above drop by one
          for (int k = old; k < t; k++) begin
            stack_slot[k] = stack_slot[k+1];
            slot_height[stack_slot[k]] = k;
          end
          top = t - 1;
        end
      end else if (old < nh) begin
        if (old >= 0) begin
          // moving up: layers in between drop by one
          for (int k = old; k < nh; k++) begin
            stack_slot[k] = stack_slot[k+1];
            slot_height[stack_slot[k]] = k;
          end
        end else begin
          // showing: layers from the new height up go up by one
          for (int k = t; k >= nh; k--) begin
            stack_slot[k+1] = stack_slot[k];
            slot_height[stack_slot[k+1]] = k + 1;
          end
          top = t + 1;
        end
        stack_slot[nh] = id;
      end
      slot_height[id] = nh;
      fin = nh;
      chg = (old != nh) ? 1 : 0;
    endfunction

    // accepted command item: update the stack and queue its result
    function void note_command(lzo_pkg::cmd_t c, lzo_pkg::layer_id_t id,
                               lzo_pkg::height_t want);
      layer_result_t e;
      int            fin;
      int            chg;
      e.layer = int'(id);
      e.status = int'(lzo_pkg::STATUS_OK);
      e.fin = -1;
      e.chg = 0;
      case (c)
        lzo_pkg::CMD_ALLOC: begin
          e.layer = 0;
          e.status = int'(lzo_pkg::STATUS_NO_FREE);
          for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_height[i] = -1;
              e.layer = i;
              e.status = int'(lzo_pkg::STATUS_OK);
              break;
            end
          end
        end
        lzo_pkg::CMD_SET: begin
          if (slot_used[id]) begin
            restack(int'(id), int'(want), fin, chg);
            e.fin = fin;
            e.chg = chg;
          end else begin
            e.status = int'(lzo_pkg::STATUS_NOT_USED);
          end
        end
        lzo_pkg::CMD_FREE: begin
          if (slot_used[id]) begin
            if (slot_height[id] >= 0) begin
              restack(int'(id), -1, fin, chg);
              e.chg = chg;
            end
            slot_used[id] = 1'b0;
          end else begin
            e.status = int'(lzo_pkg::STATUS_NOT_USED);
          end
        end
        default: begin
          if (slot_used[id]) e.fin = slot_height[id];
        end
      endcase
      e.top = top;
      awaited_results.push_back(e);
    endfunction

    function void compare_field(string what, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    // result item from the block against the oldest expectation
    function void match_result(int layer, int status, int fin, int top_h, int chg);
      layer_result_t e;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual layer %0d status %0d",
                 $time, layer, status);
        errors++;
        return;
      end
      e = awaited_results.pop_front();
      compare_field("result_layer", e.layer, layer);
      compare_field("status", e.status, status);
      compare_field("final_height", e.fin, fin);
      compare_field("top_height", e.top, top_h);
      compare_field("changed", e.chg, chg);
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [lzo_pkg::CMD_W-1:0]          in_cmd = lzo_pkg::CMD_NOP;
  logic [lzo_pkg::ID_W-1:0]           in_layer_id = '0;
  logic signed [lzo_pkg::HGT_W-1:0]   in_requested_height = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [lzo_pkg::ID_W-1:0]           out_result_layer;
  logic [lzo_pkg::STATUS_W-1:0]       out_status;
  logic signed [lzo_pkg::HGT_W-1:0]   out_final_height;
  logic signed [lzo_pkg::HGT_W-1:0]   out_top_height;
  logic                               out_changed;

  layer_stack_board board;
  int idle_pct = 0;
  int stall_pct = 0;

  layer_z_order_table dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_layer_id         (in_layer_id),
    .in_requested_height (in_requested_height),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_layer    (out_result_layer),
    .out_status          (out_status),
    .out_final_height    (out_final_height),
    .out_top_height      (out_top_height),
    .out_changed         (out_changed)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: check accepted items, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.match_result(int'(out_result_layer), int'(out_status), int'(out_final_height),
                         int'(out_top_height), int'(out_changed));
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // one command item, with random idle cycles ahead of it
  task automatic send_item(input lzo_pkg::cmd_t c, input int id, input int h);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_layer_id <= lzo_pkg::layer_id_t'(id);
    in_requested_height <= lzo_pkg::height_t'(h);
    do @(posedge clk); while (in_stall);
    board.note_command(c, lzo_pkg::layer_id_t'(id), lzo_pkg::height_t'(h));
  endtask

  // hold off until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.awaited_results.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed commands on live slots, some noise
  task automatic random_item(input int alloc_pct, input int free_pct);
    int            roll;
    lzo_pkg::cmd_t c;
    int            id;
    int            h;
    roll = $urandom_range(99);
    id = $urandom_range(SLOTS - 1);
    h = int'(lzo_pkg::height_t'($urandom));
    if (roll < alloc_pct) c = lzo_pkg::CMD_ALLOC;
    else if (roll < alloc_pct + free_pct) c = lzo_pkg::CMD_FREE;
    else if (roll < 95) c = lzo_pkg::CMD_SET;
    else c = lzo_pkg::CMD_NOP;
    if (c != lzo_pkg::CMD_ALLOC && $urandom_range(9) != 0) id = board.pick_used(id);
    if (c == lzo_pkg::CMD_SET && $urandom_range(4) != 0)
      h = int'($urandom_range(board.top + 2)) - 1;
    send_item(c, id, h);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count,
                           input int alloc_pct, input int free_pct);
    idle_pct = idle;
    stall_pct = stall;
    repeat (count) random_item(alloc_pct, free_pct);
    drain_results();
  endtask

  // run limit
  initial begin
    #40_000_000;
    $display("[layer_z_order_table] ERROR");
    $finish;
  end

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: refusals, allocation, clamping, showing and hiding moves
    send_item(lzo_pkg::CMD_SET, 0, 0);
    send_item(lzo_pkg::CMD_FREE, 5, -1);
    send_item(lzo_pkg::CMD_NOP, 255, 0);
    send_item(lzo_pkg::CMD_ALLOC, 0, 0);
    send_item(lzo_pkg::CMD_ALLOC, 0, 0);
    send_item(lzo_pkg::CMD_ALLOC, 0, 0);
    send_item(lzo_pkg::CMD_NOP, 0, 0);
    send_item(lzo_pkg::CMD_SET, 0, 255);
    send_item(lzo_pkg::CMD_SET, 1, -256);
    send_item(lzo_pkg::CMD_SET, 1, 0);
    send_item(lzo_pkg::CMD_SET, 2, 1);
    send_item(lzo_pkg::CMD_SET, 0, 255);
    send_item(lzo_pkg::CMD_SET, 1, -1);
    send_item(lzo_pkg::CMD_SET, 2, -5);
    send_item(lzo_pkg::CMD_SET, 0, 0);
    send_item(lzo_pkg::CMD_NOP, 0, 0);
    send_item(lzo_pkg::CMD_FREE, 0, 0);
    send_item(lzo_pkg::CMD_FREE, 1, 0);
    send_item(lzo_pkg::CMD_FREE, 1, 0);
    send_item(lzo_pkg::CMD_ALLOC, 0, 0);
    send_item(lzo_pkg::CMD_SET, 255, 0);
    drain_results();

    // random: grow the stack, fill every slot, then shrink it
    run_phase(0, 0, 260, 40, 8);
    run_phase(70, 0, 260, 50, 8);
    run_phase(0, 70, 270, 65, 5);
    run_phase(32, 32, 260, 15, 35);

    // wait out any stray result
    stall_pct = 0;
    repeat (300) @(posedge clk);
    if (board.errors == 0) begin
      $display("[layer_z_order_table] OK");
    end else begin
      $display("[layer_z_order_table] ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/lzo_pkg.sv
rtl/lzo_ram.sv
rtl/layer_z_order_table.sv
dv/tb_layer_z_order_table.sv
